@@ rtl/asgr_pkg.sv @@
// shared constants, command type and colour tables of the sgr text terminal
package asgr_pkg;

  // screen geometry and parser limits
  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int MAX_PARAMS     = 8;

  // derived widths: column and row hold one past the last cell for wrap checks
  localparam int COL_W   = $clog2(SCREEN_COLUMNS + 1);
  localparam int ROW_W   = $clog2(SCREEN_ROWS + 1);
  localparam int CNT_W   = $clog2(MAX_PARAMS + 1);
  localparam int IDX_W   = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

  // fixed field widths
  localparam int PARAM_W   = 14;
  localparam int ADDR_W    = 11;
  localparam int VALUE_W   = 16;
  localparam int REG_W     = 5;
  localparam int CFG_IDX_W = 2;

  // command queue between parser and executor, depth a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // byte codes
  localparam logic [7:0] BYTE_ESC      = 8'h1B;
  localparam logic [7:0] BYTE_BS       = 8'h08;
  localparam logic [7:0] BYTE_NL       = 8'h0A;
  localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
  localparam logic [7:0] BYTE_SEMI     = 8'h3B;
  localparam logic [7:0] BYTE_FINAL_M  = 8'h6D;
  localparam logic [7:0] BYTE_DIGIT_0  = 8'h30;
  localparam logic [7:0] BYTE_DIGIT_9  = 8'h39;
  localparam logic [7:0] BYTE_SPACE    = 8'h20;

  localparam logic [PARAM_W-1:0] PARAM_LIMIT = 14'd999;
  localparam logic [7:0]         ATTR_DEFAULT = 8'h0F;
  localparam logic [REG_W-1:0]   REGION_BOTTOM_RESET = 5'd24;

  // sgr parameter codes
  localparam logic [PARAM_W-1:0] SGR_RESET  = 14'd0;
  localparam logic [PARAM_W-1:0] SGR_BRIGHT = 14'd1;
  localparam logic [PARAM_W-1:0] SGR_FG_LO  = 14'd30;
  localparam logic [PARAM_W-1:0] SGR_FG_HI  = 14'd37;
  localparam logic [PARAM_W-1:0] SGR_BG_LO  = 14'd40;
  localparam logic [PARAM_W-1:0] SGR_BG_HI  = 14'd47;
  localparam logic [PARAM_W-1:0] SGR_FGB_LO = 14'd90;
  localparam logic [PARAM_W-1:0] SGR_FGB_HI = 14'd97;
  localparam logic [PARAM_W-1:0] SGR_BGB_LO = 14'd100;
  localparam logic [PARAM_W-1:0] SGR_BGB_HI = 14'd107;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_TOP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BOTTOM = 2'd1;

  // result kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SCROLL = 1'b1;

  // command codes from parser to executor
  typedef logic [2:0] cmd_op_t;
  localparam cmd_op_t CMD_PRINT = 3'd0;
  localparam cmd_op_t CMD_BS    = 3'd1;
  localparam cmd_op_t CMD_NL    = 3'd2;
  localparam cmd_op_t CMD_MOVE  = 3'd3;
  localparam cmd_op_t CMD_PARAM = 3'd4;
  localparam cmd_op_t CMD_SGR   = 3'd5;

  typedef struct packed {
    cmd_op_t              op;
    logic [7:0]           ch;
    logic [COL_W-1:0]     col;
    logic [ROW_W-1:0]     row;
    logic [PARAM_W-1:0]   value;
    logic [CNT_W-1:0]     count;
  } cmd_t;

  // colour maps
  localparam logic [3:0] MAP_FG [8] = '{4'h0, 4'h4, 4'h2, 4'hE, 4'h1, 4'h5, 4'h3, 4'hF};
  localparam logic [3:0] MAP_BG [8] = '{4'h0, 4'h4, 4'h2, 4'h6, 4'h1, 4'h5, 4'h3, 4'h7};
  localparam logic [3:0] MAP_BRIGHT [8] =
    '{4'h8, 4'hC, 4'hA, 4'hE, 4'h9, 4'hD, 4'hB, 4'hF};

  // one sgr parameter applied to the attribute (background high, foreground low)
  function automatic logic [7:0] sgr_apply(input logic [7:0] attr,
                                           input logic [PARAM_W-1:0] p);
    logic [3:0]         fg;
    logic [3:0]         bg;
    logic [PARAM_W-1:0] off;
    logic [7:0]         res;
    fg  = attr[3:0];
    bg  = attr[7:4];
    res = attr;
    off = '0;
    if (p == SGR_RESET) begin
      res = {4'h0, 4'hF};
    end else if (p == SGR_BRIGHT) begin
      res = {bg, fg | 4'h8};
    end else if (p >= SGR_FG_LO && p <= SGR_FG_HI) begin
      off = p - SGR_FG_LO;
      res = {bg, MAP_FG[off[2:0]]};
    end else if (p >= SGR_BG_LO && p <= SGR_BG_HI) begin
      off = p - SGR_BG_LO;
      res = {MAP_BG[off[2:0]], fg};
    end else if (p >= SGR_FGB_LO && p <= SGR_FGB_HI) begin
      off = p - SGR_FGB_LO;
      res = {bg, MAP_BRIGHT[off[2:0]]};
    end else if (p >= SGR_BGB_LO && p <= SGR_BGB_HI) begin
      off = p - SGR_BGB_LO;
      res = {MAP_BRIGHT[off[2:0]], fg};
    end
    return res;
  endfunction

endpackage

@@ rtl/asgr_if.sv @@
// handshake interfaces of the sgr text terminal: input, result and configuration channels

interface asgr_in_if;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [7:0]        char_byte;
  logic signed [7:0] target_column;
  logic signed [7:0] target_row;
  modport source(output valid, operation, char_byte, target_column, target_row,
                 input ready);
  modport sink(input valid, operation, char_byte, target_column, target_row,
               output ready);
endinterface

interface asgr_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [10:0] cell_address;
  logic [15:0] cell_value;
  logic        last;
  modport source(output valid, kind, cell_address, cell_value, last, input ready);
  modport sink(input valid, kind, cell_address, cell_value, last, output ready);
endinterface

interface asgr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [4:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/asgr_front.sv @@
// front end: accepts requests, runs the escape sequence parser and issues commands
module asgr_front (
  input  logic             clk,
  input  logic             rst_n,
  asgr_in_if.sink          in_if,
  output logic             q_push,
  output asgr_pkg::cmd_t   q_cmd,
  input  logic             q_full
);

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_ESC    = 2'd1;
  localparam logic [1:0] MODE_PARAM  = 2'd2;

  logic [1:0]                     mode_r, mode_nxt;
  logic [asgr_pkg::PARAM_W-1:0]   acc_r, acc_nxt;
  logic [asgr_pkg::CNT_W-1:0]     count_r, count_nxt;

  logic                           accept;
  logic                           has_cmd;
  logic                           treat_char;
  logic [7:0]                     c;
  logic [7:0]                     digit;
  logic [asgr_pkg::COL_W-1:0]     col_clamp;
  logic [asgr_pkg::ROW_W-1:0]     row_clamp;
  asgr_pkg::cmd_t                 cmd;

  // a request is taken whenever the command queue has room
  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && in_if.ready;
  assign q_push      = accept && has_cmd;
  assign q_cmd       = cmd;

  assign c     = in_if.char_byte;
  assign digit = c - asgr_pkg::BYTE_DIGIT_0;

  // clamp requested cursor position to the screen
  always_comb begin
    if (in_if.target_column[7]) begin
      col_clamp = '0;
    end else if (in_if.target_column[6:0] > 7'(asgr_pkg::SCREEN_COLUMNS - 1)) begin
      col_clamp = asgr_pkg::COL_W'(asgr_pkg::SCREEN_COLUMNS - 1);
    end else begin
      col_clamp = asgr_pkg::COL_W'(in_if.target_column[6:0]);
    end
    if (in_if.target_row[7]) begin
      row_clamp = '0;
    end else if (in_if.target_row[6:0] > 7'(asgr_pkg::SCREEN_ROWS - 1)) begin
      row_clamp = asgr_pkg::ROW_W'(asgr_pkg::SCREEN_ROWS - 1);
    end else begin
      row_clamp = asgr_pkg::ROW_W'(in_if.target_row[6:0]);
    end
  end

  // parser and classification
  always_comb begin
    mode_nxt   = mode_r;
    acc_nxt    = acc_r;
    count_nxt  = count_r;
    cmd        = '0;
    has_cmd    = 1'b0;
    treat_char = 1'b0;
    if (in_if.operation) begin
      cmd.op  = asgr_pkg::CMD_MOVE;
      cmd.col = col_clamp;
      cmd.row = row_clamp;
      has_cmd = 1'b1;
    end else begin
      unique case (mode_r)
        MODE_ESC: begin
          if (c == asgr_pkg::BYTE_LBRACKET) begin
            mode_nxt  = MODE_PARAM;
            acc_nxt   = '0;
            count_nxt = '0;
          end else begin
            // not a csi: the byte goes on as an ordinary byte
            mode_nxt   = MODE_NORMAL;
            treat_char = 1'b1;
          end
        end
        MODE_PARAM: begin
          if (c >= asgr_pkg::BYTE_DIGIT_0 && c <= asgr_pkg::BYTE_DIGIT_9) begin
            // acc * 10 + digit, frozen once past the limit
            if (acc_r <= asgr_pkg::PARAM_LIMIT) begin
              acc_nxt = asgr_pkg::PARAM_W'({acc_r, 3'b000})
                      + asgr_pkg::PARAM_W'({acc_r, 1'b0})
                      + asgr_pkg::PARAM_W'(digit[3:0]);
            end
          end else if (c == asgr_pkg::BYTE_SEMI) begin
            if (count_r < asgr_pkg::CNT_W'(asgr_pkg::MAX_PARAMS)) begin
              cmd.op    = asgr_pkg::CMD_PARAM;
              cmd.value = acc_r;
              cmd.count = count_r;
              has_cmd   = 1'b1;
              count_nxt = asgr_pkg::CNT_W'(count_r + 1'b1);
            end
            acc_nxt = '0;
          end else if (c == asgr_pkg::BYTE_FINAL_M) begin
            cmd.op    = asgr_pkg::CMD_SGR;
            cmd.value = acc_r;
            cmd.count = count_r;
            has_cmd   = 1'b1;
            mode_nxt  = MODE_NORMAL;
          end else begin
            // anything else drops the sequence
            mode_nxt = MODE_NORMAL;
          end
        end
        default: begin
          mode_nxt = MODE_NORMAL;
          if (c == asgr_pkg::BYTE_ESC) begin
            mode_nxt = MODE_ESC;
          end else begin
            treat_char = 1'b1;
          end
        end
      endcase
      if (treat_char) begin
        has_cmd = 1'b1;
        cmd.ch  = c;
        if (c == asgr_pkg::BYTE_BS) begin
          cmd.op = asgr_pkg::CMD_BS;
        end else if (c == asgr_pkg::BYTE_NL) begin
          cmd.op = asgr_pkg::CMD_NL;
        end else begin
          cmd.op = asgr_pkg::CMD_PRINT;
        end
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      acc_r   <= '0;
      count_r <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      acc_r   <= acc_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

@@ rtl/asgr_queue.sv @@
// short command queue between parser and executor
module asgr_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  asgr_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output asgr_pkg::cmd_t  head,
  output logic            head_valid
);

  asgr_pkg::cmd_t                 slot_r [asgr_pkg::QUEUE_DEPTH];
  logic [asgr_pkg::QPTR_W-1:0]    wr_ptr_r;
  logic [asgr_pkg::QPTR_W-1:0]    rd_ptr_r;
  logic [asgr_pkg::QCNT_W-1:0]    fill_r;

  assign full       = (fill_r == asgr_pkg::QCNT_W'(asgr_pkg::QUEUE_DEPTH));
  assign head_valid = (fill_r != '0);
  assign head       = slot_r[rd_ptr_r];

  // pointers wrap naturally over the power-of-two depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= asgr_pkg::QPTR_W'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= asgr_pkg::QPTR_W'(rd_ptr_r + 1'b1);
      end
      if (push && !pop) begin
        fill_r <= asgr_pkg::QCNT_W'(fill_r + 1'b1);
      end else if (pop && !push) begin
        fill_r <= asgr_pkg::QCNT_W'(fill_r - 1'b1);
      end
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/asgr_back.sv @@
// back end: cursor, colour attribute, sgr walk and result register
module asgr_back (
  input  logic            clk,
  input  logic            rst_n,
  input  asgr_pkg::cmd_t  head,
  input  logic            head_valid,
  output logic            pop,
  asgr_cfg_if.sink        cfg_if,
  asgr_out_if.source      out_if
);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_WRITE2  = 2'd1;
  localparam logic [1:0] ST_SCROLL2 = 2'd2;
  localparam logic [1:0] ST_SGR     = 2'd3;

  logic [1:0]                    state_r, state_nxt;
  logic [7:0]                    attr_r, attr_nxt;
  logic [asgr_pkg::COL_W-1:0]    col_r, col_nxt;
  logic [asgr_pkg::ROW_W-1:0]    row_r, row_nxt;
  logic [7:0]                    char_r, char_nxt;
  logic [asgr_pkg::IDX_W-1:0]    walk_r, walk_nxt;
  logic [asgr_pkg::IDX_W-1:0]    walk_end_r, walk_end_nxt;
  logic [asgr_pkg::REG_W-1:0]    bottom_r;
  logic [asgr_pkg::PARAM_W-1:0]  pstore_r [asgr_pkg::MAX_PARAMS];

  logic                          pstore_we;
  logic [asgr_pkg::IDX_W-1:0]    pstore_idx;

  logic                          out_valid_r;
  logic                          out_kind_r;
  logic [asgr_pkg::ADDR_W-1:0]   out_addr_r;
  logic [asgr_pkg::VALUE_W-1:0]  out_value_r;
  logic                          out_last_r;

  logic                          out_free;
  logic                          emit;
  logic                          e_kind;
  logic [asgr_pkg::VALUE_W-1:0]  e_value;
  logic                          e_last;
  logic [asgr_pkg::ADDR_W-1:0]   e_addr;
  logic [asgr_pkg::ROW_W-1:0]    a_row;
  logic [asgr_pkg::COL_W-1:0]    a_col;
  logic [asgr_pkg::ADDR_W-1:0]   cell_addr;

  logic [asgr_pkg::ROW_W-1:0]    eb;
  logic [asgr_pkg::COL_W-1:0]    col_w;
  logic [asgr_pkg::ROW_W-1:0]    row_w;
  logic [asgr_pkg::COL_W-1:0]    col_w_inc;
  logic [asgr_pkg::ROW_W-1:0]    row_w_inc;
  logic [asgr_pkg::COL_W-1:0]    col_inc;
  logic [asgr_pkg::ROW_W-1:0]    row_inc;

  // configuration: the region top row is for the display engine only
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bottom_r <= asgr_pkg::REGION_BOTTOM_RESET;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        asgr_pkg::CFG_REGION_TOP: ;
        asgr_pkg::CFG_REGION_BOTTOM: bottom_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // effective bottom row of the scrolling region
  assign eb = (bottom_r > asgr_pkg::REG_W'(asgr_pkg::SCREEN_ROWS - 1)) ?
              asgr_pkg::ROW_W'(asgr_pkg::SCREEN_ROWS - 1) : asgr_pkg::ROW_W'(bottom_r);

  // wrap of a cursor parked past the last column
  always_comb begin
    if (col_r >= asgr_pkg::COL_W'(asgr_pkg::SCREEN_COLUMNS)) begin
      col_w = '0;
      row_w = asgr_pkg::ROW_W'(row_r + 1'b1);
    end else begin
      col_w = col_r;
      row_w = row_r;
    end
  end

  assign col_w_inc = asgr_pkg::COL_W'(col_w + 1'b1);
  assign row_w_inc = asgr_pkg::ROW_W'(row_w + 1'b1);
  assign col_inc   = asgr_pkg::COL_W'(col_r + 1'b1);
  assign row_inc   = asgr_pkg::ROW_W'(row_r + 1'b1);

  // single address unit: row * columns + column
  assign cell_addr = asgr_pkg::ADDR_W'(a_row * asgr_pkg::ADDR_W'(asgr_pkg::SCREEN_COLUMNS))
                   + asgr_pkg::ADDR_W'(a_col);
  assign e_addr    = (e_kind == asgr_pkg::KIND_SCROLL) ? '0 : cell_addr;

  assign out_free = !out_valid_r || out_if.ready;

  // executor sequencer
  always_comb begin
    state_nxt    = state_r;
    attr_nxt     = attr_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    char_nxt     = char_r;
    walk_nxt     = walk_r;
    walk_end_nxt = walk_end_r;
    pop          = 1'b0;
    pstore_we    = 1'b0;
    pstore_idx   = asgr_pkg::IDX_W'(head.count);
    emit         = 1'b0;
    e_kind       = asgr_pkg::KIND_WRITE;
    e_value      = {attr_r, asgr_pkg::BYTE_SPACE};
    e_last       = 1'b1;
    a_row        = row_r;
    a_col        = col_r;
    unique case (state_r)
      ST_IDLE: begin
        if (head_valid && out_free) begin
          pop = 1'b1;
          unique case (head.op)
            asgr_pkg::CMD_PRINT: begin
              if (row_w > eb) begin
                // below the region: scroll first, then write at column 0
                emit      = 1'b1;
                e_kind    = asgr_pkg::KIND_SCROLL;
                e_last    = 1'b0;
                col_nxt   = '0;
                row_nxt   = eb;
                char_nxt  = head.ch;
                state_nxt = ST_WRITE2;
              end else begin
                emit    = 1'b1;
                a_row   = row_w;
                a_col   = col_w;
                e_value = {attr_r, head.ch};
                if (col_w_inc >= asgr_pkg::COL_W'(asgr_pkg::SCREEN_COLUMNS)) begin
                  col_nxt = '0;
                  row_nxt = row_w_inc;
                  if (row_w_inc > eb) begin
                    // wrap past the region bottom adds a scroll
                    e_last    = 1'b0;
                    state_nxt = ST_SCROLL2;
                  end
                end else begin
                  col_nxt = col_w_inc;
                  row_nxt = row_w;
                end
              end
            end
            asgr_pkg::CMD_BS: begin
              if (col_r != '0) begin
                emit    = 1'b1;
                a_col   = asgr_pkg::COL_W'(col_r - 1'b1);
                col_nxt = asgr_pkg::COL_W'(col_r - 1'b1);
              end
            end
            asgr_pkg::CMD_NL: begin
              col_nxt = '0;
              if (row_inc > eb) begin
                emit    = 1'b1;
                e_kind  = asgr_pkg::KIND_SCROLL;
                row_nxt = eb;
              end else begin
                row_nxt = row_inc;
              end
            end
            asgr_pkg::CMD_MOVE: begin
              col_nxt = head.col;
              row_nxt = head.row;
            end
            asgr_pkg::CMD_PARAM: begin
              pstore_we = 1'b1;
            end
            asgr_pkg::CMD_SGR: begin
              // final parameter joins the store, then walk every stored entry
              if (head.count < asgr_pkg::CNT_W'(asgr_pkg::MAX_PARAMS)) begin
                pstore_we    = 1'b1;
                walk_end_nxt = asgr_pkg::IDX_W'(head.count);
              end else begin
                walk_end_nxt = asgr_pkg::IDX_W'(asgr_pkg::MAX_PARAMS - 1);
              end
              walk_nxt  = '0;
              state_nxt = ST_SGR;
            end
            default: ;
          endcase
        end
      end
      ST_WRITE2: begin
        if (out_free) begin
          emit    = 1'b1;
          e_value = {attr_r, char_r};
          if (col_inc >= asgr_pkg::COL_W'(asgr_pkg::SCREEN_COLUMNS)) begin
            col_nxt = '0;
            row_nxt = row_inc;
          end else begin
            col_nxt = col_inc;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_SCROLL2: begin
        if (out_free) begin
          emit      = 1'b1;
          e_kind    = asgr_pkg::KIND_SCROLL;
          col_nxt   = '0;
          row_nxt   = eb;
          state_nxt = ST_IDLE;
        end
      end
      ST_SGR: begin
        attr_nxt = asgr_pkg::sgr_apply(attr_r, pstore_r[walk_r]);
        if (walk_r == walk_end_r) begin
          state_nxt = ST_IDLE;
        end else begin
          walk_nxt = asgr_pkg::IDX_W'(walk_r + 1'b1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // executor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      attr_r  <= asgr_pkg::ATTR_DEFAULT;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      attr_r  <= attr_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r     <= char_nxt;
    walk_r     <= walk_nxt;
    walk_end_r <= walk_end_nxt;
  end

  // parameter store
  always_ff @(posedge clk) begin
    if (pstore_we) begin
      pstore_r[pstore_idx] <= head.value;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r  <= e_kind;
      out_addr_r  <= e_addr;
      out_value_r <= e_value;
      out_last_r  <= e_last;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.kind         = out_kind_r;
  assign out_if.cell_address = out_addr_r;
  assign out_if.cell_value   = out_value_r;
  assign out_if.last         = out_last_r;

endmodule

@@ rtl/ansi_sgr_text_terminal_core.sv @@
// top level of the ansi sgr text terminal
// Takes terminal bytes and cursor moves on in_if and gives cell writes and scroll
// requests on out_if. A parser front end takes one request per cycle while its
// four-entry command queue has room; the executor behind the queue takes no new
// command while it gives the second result of a printable byte that also scrolls
// (a cell write and a scroll request) or walks the parameter store, one entry per
// cycle, for the final m of an sgr sequence with n stored parameters (at most
// eight). Plain text therefore flows at one request per cycle while the output
// takes results; a scroll from a printable byte or an sgr walk holds the executor
// while the queue keeps taking bytes, and the input stalls once the queue is full.
// Results leave through one output register, and a held result stops the executor;
// the region top row is accepted on cfg_if but only the display engine uses it.
module ansi_sgr_text_terminal_core (
  input  logic        clk,
  input  logic        rst_n,
  asgr_in_if.sink     in_if,
  asgr_out_if.source  out_if,
  asgr_cfg_if.sink    cfg_if
);

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_head_valid;
  asgr_pkg::cmd_t  q_cmd;
  asgr_pkg::cmd_t  q_head;

  // parser
  asgr_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .q_push (q_push),
    .q_cmd  (q_cmd),
    .q_full (q_full)
  );

  // command queue
  asgr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_head_valid)
  );

  // executor
  asgr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (q_head_valid),
    .pop        (q_pop),
    .cfg_if     (cfg_if),
    .out_if     (out_if)
  );

endmodule

@@ rtl/asgr_checker.sv @@
// port-level checks of the sgr text terminal and their binding to the top level
module asgr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_kind,
  input logic [asgr_pkg::ADDR_W-1:0]   out_addr,
  input logic [asgr_pkg::VALUE_W-1:0]  out_value,
  input logic                          out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_addr)
      && $stable(out_value) && $stable(out_last))
    else $error("result changed while stalled");

  // scroll requests carry address zero and a blank fill
  a_scroll_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == asgr_pkg::KIND_SCROLL |->
      out_addr == '0 && out_value[7:0] == asgr_pkg::BYTE_SPACE)
    else $error("malformed scroll request");

  // cell writes stay on the screen
  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == asgr_pkg::KIND_WRITE |->
      out_addr < asgr_pkg::ADDR_W'(asgr_pkg::SCREEN_COLUMNS * asgr_pkg::SCREEN_ROWS))
    else $error("cell write off screen");

  // nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result right after reset");

endmodule

bind ansi_sgr_text_terminal_core asgr_checker u_asgr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_kind  (out_if.kind),
  .out_addr  (out_if.cell_address),
  .out_value (out_if.cell_value),
  .out_last  (out_if.last)
);
